FILE: rtl/core/ewm_pkg.sv
// ----------------------------------------------------------------------------
// ewm_pkg: shared types and constants
// Field widths, register codes and the control bundle for the average unit.
// ----------------------------------------------------------------------------
package ewm_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int AVG_W      = 32;
	localparam int COUNT_W    = 32;
	localparam int ALPHA_W    = 17;
	localparam int AGE_W      = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;

	// x*65536 - avg needs one bit more than the average
	localparam int DIFF_W = AVG_W + 1;
	// 17-bit signed weight times the difference
	localparam int PROD_W = DIFF_W + ALPHA_W;

	localparam logic [AGE_W-1:0]   AGE_MAX         = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 17'd65536;
	localparam logic [AGE_W-1:0]   AGE_LIMIT_RESET = 6'd8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT = 1'd1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [AVG_W-1:0]    avg_t;

	typedef struct packed {
		logic load;    // sample beat taken: form the weighted step
		logic update;  // fold the step into the average
		logic first;   // beat opens a new set
	} ewm_avg_ctl_t;

endpackage

FILE: rtl/core/ewm_if.sv
// ----------------------------------------------------------------------------
// ewm_if: channel interfaces
// Sample stream, result stream and register write channel.
// ----------------------------------------------------------------------------
interface ewm_in_if import ewm_pkg::*;;
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    first;

	modport source (output valid, output sample, output first, input ready);
	modport sink   (input valid, input sample, input first, output ready);
endinterface

interface ewm_out_if import ewm_pkg::*;;
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] sample_number;
	sample_t            value;
	sample_t            window_min;
	avg_t               average;
	sample_t            window_max;

	modport source (output valid, output sample_number, output value, output window_min,
		output average, output window_max, input ready);
	modport sink   (input valid, input sample_number, input value, input window_min,
		input average, input window_max, output ready);
endinterface

interface ewm_cfg_if import ewm_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/ewm_cell.sv
// ----------------------------------------------------------------------------
// ewm_cell: one history cell
// Holds one sample and takes its neighbor's value on every shift.
// ----------------------------------------------------------------------------
module ewm_cell import ewm_pkg::*; (
	input  logic    clk,
	input  logic    shift,
	input  sample_t din,
	output sample_t dout
);

	sample_t sample_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			sample_q <= din;
		end
	end

	assign dout = sample_q;

endmodule

FILE: rtl/core/ewm_avg.sv
// ----------------------------------------------------------------------------
// ewm_avg: exponential average unit
// Weighted step registered after the multiply, then added with saturation.
// ----------------------------------------------------------------------------
module ewm_avg import ewm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ewm_avg_ctl_t       ctl,
	input  sample_t            x,
	input  logic [ALPHA_W-1:0] alpha,
	output avg_t               avg
);

	localparam int Q_W   = PROD_W - 16;
	localparam int SUM_W = Q_W + 1;

	avg_t                     avg_q;
	avg_t                     xs;
	avg_t                     xs_s1;
	logic                     first_s1;
	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [Q_W-1:0]    step;
	logic signed [SUM_W-1:0]  sum;
	avg_t                     sum_sat;

	assign xs   = $signed({x, 16'h0000});
	assign diff = DIFF_W'(xs) - DIFF_W'(avg_q);

	// weight of 1.0 or more passes the difference through unscaled
	always_comb begin
		if (alpha[ALPHA_W-1]) begin
			prod = PROD_W'($signed({diff, 16'h0000}));
		end else begin
			prod = $signed({1'b0, alpha[ALPHA_W-2:0]}) * diff;
		end
	end

	// arithmetic shift gives the floor of the division by 65536
	assign step = prod_s1[PROD_W-1:16];
	assign sum  = SUM_W'(avg_q) + SUM_W'(step);

	always_comb begin
		if ((&sum[SUM_W-1:AVG_W-1]) || !(|sum[SUM_W-1:AVG_W-1])) begin
			sum_sat = sum[AVG_W-1:0];
		end else if (sum[SUM_W-1]) begin
			sum_sat = {1'b1, {(AVG_W-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(AVG_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			prod_s1  <= prod;
			xs_s1    <= xs;
			first_s1 <= ctl.first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
		end else if (ctl.update) begin
			avg_q <= first_s1 ? xs_s1 : sum_sat;
		end
	end

	assign avg = avg_q;

endmodule

FILE: rtl/core/ewma_window_min_max.sv
// ----------------------------------------------------------------------------
// ewma_window_min_max: running average and windowed extremes
// Signed sample stream in; per sample the count, the sample, the window
// minimum and maximum and the exponential average out.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                         | beat when
//  ---------+-----+-------------------------------------------------+-------------
//  samples  | in  | sample, first                                   | valid & ready
//  results  | out | sample_number, value, window_min, average,      | valid & ready
//           |     | window_max                                      |
//  cfg      | in  | index (0 alpha, 1 age_limit), data              | valid & ready
//
//  After its beat a sample passes through CALC and DONE before the block is ready again.
//  When a minimum or maximum has aged out, SCAN comes between CALC and DONE: the history
//  ring turns once around its WINDOW cells and the scan sees one cell a cycle.
//  The result sits in an output register; a stalled result only holds the
//  next sample in its last step. Reset clears count, average and extremes;
//  history cells hold nothing defined until written. cfg is always ready.
//
module ewma_window_min_max import ewm_pkg::*; #(
	parameter int WINDOW = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	ewm_in_if.sink           samples,
	ewm_out_if.source        results,
	ewm_cfg_if.sink          cfg
);

	localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW    = (CNT_W > AGE_W) ? CNT_W : AGE_W;
	localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(WINDOW - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CALC = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_DONE = 4'b1000
	} ewm_state_t;

	ewm_state_t state_q;

	// registers
	logic [ALPHA_W-1:0] alpha_q;
	logic [AGE_W-1:0]   age_limit_q;
	logic [AGE_W-1:0]   lim;

	// running state
	logic [COUNT_W-1:0] count_q;
	sample_t            cur_min_q;
	sample_t            cur_max_q;
	logic [AGE_W-1:0]   min_age_q;
	logic [AGE_W-1:0]   max_age_q;
	logic               need_min_q;
	logic               need_max_q;
	sample_t            x_q;

	// accept-cycle update of the extremes
	logic               acc;
	logic [AGE_W-1:0]   min_age_inc;
	logic [AGE_W-1:0]   max_age_inc;
	sample_t            min_upd;
	sample_t            max_upd;
	logic [AGE_W-1:0]   min_age_upd;
	logic [AGE_W-1:0]   max_age_upd;

	// history chain
	sample_t            hist [WINDOW];
	sample_t            head_in;
	logic               shift;

	// scan
	logic [CNT_W-1:0]   scan_cnt_q;
	logic [CNT_W-1:0]   scan_dist;
	logic               in_win;
	logic               oldest;
	sample_t            tail;
	sample_t            smin_q;
	sample_t            smax_q;
	logic [AGE_W-1:0]   smin_age_q;
	logic [AGE_W-1:0]   smax_age_q;

	// finish
	logic               out_free;
	logic               out_load;
	sample_t            min_fin;
	sample_t            max_fin;

	ewm_avg_ctl_t       avg_ctl;
	avg_t               avg;

	//---------------------------------------------------------------- config
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= ALPHA_RESET;
			age_limit_q <= AGE_LIMIT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ALPHA:     alpha_q     <= cfg.data[ALPHA_W-1:0];
				CFG_AGE_LIMIT: age_limit_q <= cfg.data[AGE_W-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, anything past the ring acts as the ring length
	always_comb begin
		if (age_limit_q == '0) begin
			lim = AGE_W'(1);
		end else if (32'(age_limit_q) > WINDOW) begin
			lim = AGE_W'(WINDOW);
		end else begin
			lim = age_limit_q;
		end
	end

	//---------------------------------------------------------------- intake
	assign samples.ready = (state_q == ST_IDLE);
	assign acc           = samples.valid && samples.ready;

	assign min_age_inc = (min_age_q == AGE_MAX) ? AGE_MAX : min_age_q + AGE_W'(1);
	assign max_age_inc = (max_age_q == AGE_MAX) ? AGE_MAX : max_age_q + AGE_W'(1);

	// ties go to the new sample: it is the younger one
	always_comb begin
		if (samples.first || samples.sample <= cur_min_q) begin
			min_upd     = samples.sample;
			min_age_upd = '0;
		end else begin
			min_upd     = cur_min_q;
			min_age_upd = min_age_inc;
		end
		if (samples.first || samples.sample >= cur_max_q) begin
			max_upd     = samples.sample;
			max_age_upd = '0;
		end else begin
			max_upd     = cur_max_q;
			max_age_upd = max_age_inc;
		end
	end

	//---------------------------------------------------------------- history
	// Cell 0 is the newest sample. During a scan the ring turns: the oldest
	// cell feeds cell 0, and after one full turn every sample is back in place.
	assign shift   = acc || (state_q == ST_SCAN);
	assign head_in = (state_q == ST_SCAN) ? tail : samples.sample;
	assign tail    = hist[WINDOW-1];

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		ewm_cell u_cell (
			.clk   (clk),
			.shift (shift),
			.din   ((i == 0) ? head_in : hist[(i == 0) ? 0 : i - 1]),
			.dout  (hist[i])
		);
	end

	//---------------------------------------------------------------- scan
	// On turn k the tail holds the sample k places from the oldest cell,
	// i.e. distance WINDOW-1-k from the newest. Only distances below the
	// limit count; they arrive oldest first, so >= and <= keep the newest.
	assign scan_dist = SCAN_LAST - scan_cnt_q;
	assign in_win    = CW'(scan_dist) < CW'(lim);
	assign oldest    = CW'(scan_dist) == CW'(lim) - CW'(1);

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && in_win) begin
			if (oldest || tail <= smin_q) begin
				smin_q     <= tail;
				smin_age_q <= AGE_W'(scan_dist);
			end
			if (oldest || tail >= smax_q) begin
				smax_q     <= tail;
				smax_age_q <= AGE_W'(scan_dist);
			end
		end
	end

	//---------------------------------------------------------------- average
	assign avg_ctl.load   = acc;
	assign avg_ctl.update = (state_q == ST_CALC);
	assign avg_ctl.first  = samples.first;

	ewm_avg u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (avg_ctl),
		.x      (samples.sample),
		.alpha  (alpha_q),
		.avg    (avg)
	);

	//---------------------------------------------------------------- finish
	assign out_free = !results.valid || results.ready;
	assign out_load = (state_q == ST_DONE) && out_free;
	assign min_fin  = need_min_q ? smin_q : cur_min_q;
	assign max_fin  = need_max_q ? smax_q : cur_max_q;

	//---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_cnt_q <= '0;
			count_q    <= '0;
			cur_min_q  <= '0;
			cur_max_q  <= '0;
			min_age_q  <= '0;
			max_age_q  <= '0;
			need_min_q <= 1'b0;
			need_max_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q    <= ST_CALC;
						cur_min_q  <= min_upd;
						cur_max_q  <= max_upd;
						min_age_q  <= min_age_upd;
						max_age_q  <= max_age_upd;
						need_min_q <= !samples.first && (min_age_upd >= lim);
						need_max_q <= !samples.first && (max_age_upd >= lim);
						if (samples.first) begin
							count_q <= COUNT_W'(1);
						end else if (count_q != COUNT_MAX) begin
							count_q <= count_q + COUNT_W'(1);
						end
					end
				end
				ST_CALC: begin
					scan_cnt_q <= '0;
					state_q    <= (need_min_q || need_max_q) ? ST_SCAN : ST_DONE;
				end
				ST_SCAN: begin
					scan_cnt_q <= scan_cnt_q + CNT_W'(1);
					if (scan_cnt_q == SCAN_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q    <= ST_IDLE;
						cur_min_q  <= min_fin;
						cur_max_q  <= max_fin;
						need_min_q <= 1'b0;
						need_max_q <= 1'b0;
						if (need_min_q) begin
							min_age_q <= smin_age_q;
						end
						if (need_max_q) begin
							max_age_q <= smax_age_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x_q <= samples.sample;
		end
	end

	//---------------------------------------------------------------- output
	logic               out_valid_q;
	logic [COUNT_W-1:0] out_count_q;
	sample_t            out_value_q;
	sample_t            out_min_q;
	avg_t               out_avg_q;
	sample_t            out_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_count_q <= count_q;
			out_value_q <= x_q;
			out_min_q   <= min_fin;
			out_avg_q   <= avg;
			out_max_q   <= max_fin;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.sample_number = out_count_q;
	assign results.value         = out_value_q;
	assign results.window_min    = out_min_q;
	assign results.average       = out_avg_q;
	assign results.window_max    = out_max_q;

	//---------------------------------------------------------------- checks
	a_accept_to_calc: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q == ST_CALC)
		else $error("sample beat not followed by average step");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_cnt_q == SCAN_LAST) |=> state_q == ST_DONE)
		else $error("ring scan did not end after one full turn");

	a_scan_age: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && need_min_q) |-> smin_age_q < lim)
		else $error("rescanned minimum lies outside the window");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.window_min <= results.value &&
			results.value <= results.window_max))
		else $error("window extremes do not bracket the sample");

endmodule
